// ----- hdl/psf_pkg.sv -----
// Shared types, constants and a helper function of the pose slew follower.
`default_nettype none
package psf_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned HD_W       = 16;
  localparam int unsigned DT_W       = 20;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned MOVE_W     = 24;
  localparam int unsigned TURN_W     = 19;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned DIST_W     = 33;
  localparam int unsigned DIV_NUM_W  = 57;
  localparam int unsigned DIV_DEN_W  = 33;
  localparam int unsigned DIV_Q_W    = 26;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned SQ_IN_W    = 64;
  localparam int unsigned SQ_OUT_W   = 32;
  localparam int unsigned SQ_CNT_W   = 5;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_SNAP = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd2560;
  localparam logic [MOVE_W-1:0] MOVE_RST = 24'd25600;
  localparam logic [TURN_W-1:0] TURN_RST = 19'd92160;

  localparam logic signed [17:0] YAW_HALF     = 18'sd23040;
  localparam logic signed [17:0] YAW_FULL     = 18'sd46080;
  localparam logic signed [20:0] YAW_DEADBAND = 21'sd13;
  localparam logic [63:0]        NEAR_SUMSQ   = 64'd6;
  localparam logic [27:0]        POS_DIV      = 28'd256000000;

  // Both constant divisions reduce to a division by 15625 of a value below 2^38,
  // done as a multiplication by floor(2^38 / 15625) and one correction step.
  localparam logic [24:0] RCP_M = 25'd17592186;
  localparam logic [13:0] RCP_D = 14'd15625;

  typedef enum logic [3:0] {
    OP_SET  = 4'b0001,
    OP_SNAP = 4'b0010,
    OP_TICK = 4'b0100,
    OP_NONE = 4'b1000
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [HD_W-1:0]  hd;
    logic [DT_W-1:0]         dt;
  } item_t;

  function automatic logic signed [HD_W-1:0] wrap_yaw(input logic signed [17:0] v);
    logic signed [17:0] t;
    t = v;
    if (t > YAW_HALF) begin
      t = t - YAW_FULL;
    end else if (t <= -YAW_HALF) begin
      t = t + YAW_FULL;
    end
    return t[HD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/psf_front.sv -----
// Front end: accepts items, classifies their kind and queues them for the back end.
`default_nettype none
module psf_front import psf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_kind,
  input  wire logic signed [POS_W-1:0] in_pos_x,
  input  wire logic signed [POS_W-1:0] in_pos_y,
  input  wire logic signed [POS_W-1:0] in_pos_z,
  input  wire logic signed [HD_W-1:0]  in_heading,
  input  wire logic [DT_W-1:0]         in_elapsed_us,
  output logic                         q_valid,
  output item_t                        q_item,
  input  wire logic                    q_pop
);

  item_t      mem_r [2];
  item_t      wr_item;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  op_t        op;

  always_comb begin
    unique case (in_kind)
      KIND_SET:  op = OP_SET;
      KIND_SNAP: op = OP_SNAP;
      KIND_TICK: op = OP_TICK;
      default:   op = OP_NONE;
    endcase
  end

  assign wr_item  = '{op: op, x: in_pos_x, y: in_pos_y, z: in_pos_z,
                      hd: in_heading, dt: in_elapsed_us};
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/psf_sqrt.sv -----
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module psf_sqrt import psf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SQ_IN_W-1:0]  rad,
  output logic                     done,
  output logic [SQ_OUT_W-1:0]      root
);

  logic [SQ_IN_W-1:0]  rad_r;
  logic [SQ_OUT_W:0]   rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SQ_OUT_W+2:0] rem_sh;
  logic [SQ_OUT_W+2:0] trial;
  logic [SQ_OUT_W+2:0] rem_new;
  logic                ge;

  assign rem_sh  = {rem_r, rad_r[SQ_IN_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_new = ge ? (rem_sh - trial) : rem_sh;
  assign done    = done_r;
  assign root    = root_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= SQ_CNT_W'(SQ_OUT_W - 1);
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQ_IN_W-3:0], 2'b00};
      rem_r  <= rem_new[SQ_OUT_W:0];
      root_r <= {root_r[SQ_OUT_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/psf_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module psf_div import psf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_Q_W-1:0]        quo
);

  localparam int unsigned DSH_W = DIV_DEN_W + DIV_Q_W - 1;

  logic [DIV_NUM_W-1:0] rem_r;
  logic [DSH_W-1:0]     dsh_r;
  logic [DIV_Q_W-1:0]   quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 ge;

  assign ge   = ({{(DSH_W-DIV_NUM_W){1'b0}}, rem_r} >= dsh_r);
  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {(DIV_Q_W-1){1'b0}}};
      quo_r <= '0;
      cnt_r <= DIV_CNT_W'(DIV_Q_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[DIV_NUM_W-1:0];
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[DIV_Q_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/psf_back.sv -----
// Back end: holds the pose, runs the tick sequence and drives the result register.
`default_nettype none
module psf_back import psf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  input  wire item_t                   q_item,
  output logic                         q_pop,
  input  wire logic [GAIN_W-1:0]       cfg_gain,
  input  wire logic [MOVE_W-1:0]       cfg_move,
  input  wire logic [TURN_W-1:0]       cfg_turn,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [POS_W-1:0]      out_cur_x,
  output logic signed [POS_W-1:0]      out_cur_y,
  output logic signed [POS_W-1:0]      out_cur_z,
  output logic signed [HD_W-1:0]       out_cur_heading
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_SQ      = 15'b000000000000010,
    S_CHK     = 15'b000000000000100,
    S_SQRT    = 15'b000000000001000,
    S_PA      = 15'b000000000010000,
    S_PB      = 15'b000000000100000,
    S_STEP    = 15'b000000001000000,
    S_RM      = 15'b000000010000000,
    S_RS      = 15'b000000100000000,
    S_RC      = 15'b000001000000000,
    S_MUL     = 15'b000010000000000,
    S_MVST    = 15'b000100000000000,
    S_MOVEDIV = 15'b001000000000000,
    S_YAW     = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0] now_r [3];
  logic signed [POS_W-1:0] goal_r [3];
  logic signed [HD_W-1:0]  hdn_r, hdg_r;
  logic [DT_W-1:0]         dt_r;
  logic [DIST_W-1:0]       ad_r [3];
  logic                    neg_r [3];
  logic [63:0]             sum_r;
  logic [1:0]              cnt_r;
  logic [DIST_W-1:0]       dist_r;
  logic [48:0]             pa_r;
  logic [68:0]             pb_r;
  logic [51:0]             lim_r;
  logic [MOVE_W-1:0]       step_r;
  logic [DIV_NUM_W-1:0]    mp_r;
  logic [38:0]             tp_r;
  logic [37:0]             rx_r;
  logic [43:0]             rpl_r, rph_r;
  logic [24:0]             rq_r;
  logic                    yaw_r;
  logic signed [POS_W-1:0] ox_r, oy_r, oz_r;
  logic signed [HD_W-1:0]  oh_r;

  logic                    sh;
  logic [DIST_W-1:0]       ad_sel;
  logic [31:0]             h;
  logic [63:0]             sq;
  logic                    near;
  logic                    over;
  logic                    out_free;
  logic                    sqrt_start, sqrt_done;
  logic [SQ_OUT_W-1:0]     root;
  logic                    div_start, div_done;
  logic [DIV_Q_W-1:0]      quo;
  logic [62:0]             rsum;
  logic [38:0]             rprod;
  logic [38:0]             rrem;
  logic [24:0]             rq_fix;
  logic [32:0]             dg [3];
  logic signed [33:0]      mv;
  logic signed [33:0]      pos_sum;
  logic signed [POS_W-1:0] pos_sat;
  logic signed [HD_W-1:0]  err;
  logic signed [20:0]      err_w, lim_w, err_c;
  logic signed [HD_W-1:0]  hd_new;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dg[i] = {goal_r[i][POS_W-1], goal_r[i]} - {now_r[i][POS_W-1], now_r[i]};
    end
  end

  assign sh = ad_r[0][32] | ad_r[0][31] | ad_r[1][32] | ad_r[1][31] |
              ad_r[2][32] | ad_r[2][31];

  always_comb begin
    unique case (cnt_r)
      2'd0:    ad_sel = ad_r[0];
      2'd1:    ad_sel = ad_r[1];
      default: ad_sel = ad_r[2];
    endcase
  end

  assign h        = sh ? ad_sel[32:1] : ad_sel[31:0];
  assign sq       = {32'b0, h} * {32'b0, h};
  assign near     = !sh && (sum_r <= NEAR_SUMSQ);
  assign over     = (pb_r > {17'b0, lim_r});
  assign out_free = !out_valid_r || out_ready;

  assign rsum   = {rph_r, 19'b0} + {19'b0, rpl_r};
  assign rprod  = {14'b0, rq_r} * {25'b0, RCP_D};
  assign rrem   = {1'b0, rx_r} - rprod;
  assign rq_fix = (rrem >= {25'b0, RCP_D}) ? (rq_r + 25'd1) : rq_r;

  assign mv      = neg_r[cnt_r] ? -$signed({8'b0, quo}) : $signed({8'b0, quo});
  assign pos_sum = $signed({now_r[cnt_r][POS_W-1], now_r[cnt_r][POS_W-1], now_r[cnt_r]}) + mv;

  always_comb begin
    if (pos_sum > 34'sh07FFFFFFF) begin
      pos_sat = 32'sh7FFFFFFF;
    end else if (pos_sum < -34'sh080000000) begin
      pos_sat = -32'sh80000000;
    end else begin
      pos_sat = pos_sum[POS_W-1:0];
    end
  end

  assign err   = wrap_yaw(18'(hdg_r) - 18'(hdn_r));
  assign err_w = 21'(err);
  assign lim_w = $signed({1'b0, rq_r[19:0]});

  always_comb begin
    err_c = err_w;
    if (err_w > lim_w) begin
      err_c = lim_w;
    end
    if (err_w < -lim_w) begin
      err_c = -lim_w;
    end
  end

  assign hd_new = wrap_yaw(18'(hdn_r) + err_c[17:0]);

  assign sqrt_start = (state_r == S_CHK) && !near;
  assign div_start  = (state_r == S_MVST);

  psf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sum_r),
    .done  (sqrt_done),
    .root  (root)
  );

  psf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mp_r),
    .den   (dist_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = (q_item.op == OP_TICK) ? S_SQ : S_DONE;
        end
      end
      S_SQ:      state_nxt = (cnt_r == 2'd2) ? S_CHK : S_SQ;
      S_CHK:     state_nxt = near ? S_RM : S_SQRT;
      S_SQRT:    state_nxt = sqrt_done ? S_PA : S_SQRT;
      S_PA:      state_nxt = S_PB;
      S_PB:      state_nxt = S_STEP;
      S_STEP:    state_nxt = over ? S_MUL : S_RM;
      S_RM:      state_nxt = S_RS;
      S_RS:      state_nxt = S_RC;
      S_RC:      state_nxt = yaw_r ? S_YAW : S_MUL;
      S_MUL:     state_nxt = S_MVST;
      S_MVST:    state_nxt = S_MOVEDIV;
      S_MOVEDIV: begin
        if (div_done) begin
          state_nxt = (cnt_r == 2'd2) ? S_RM : S_MUL;
        end
      end
      S_YAW:     state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        now_r[i]  <= '0;
        goal_r[i] <= '0;
      end
      hdn_r <= '0;
      hdg_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && (q_item.op == OP_SET || q_item.op == OP_SNAP)) begin
            goal_r[0] <= q_item.x;
            goal_r[1] <= q_item.y;
            goal_r[2] <= q_item.z;
            hdg_r     <= q_item.hd;
            if (q_item.op == OP_SNAP) begin
              now_r[0] <= q_item.x;
              now_r[1] <= q_item.y;
              now_r[2] <= q_item.z;
              hdn_r    <= wrap_yaw(18'(q_item.hd));
            end
          end
        end
        S_CHK: begin
          if (near) begin
            for (int i = 0; i < 3; i++) begin
              now_r[i] <= goal_r[i];
            end
          end
        end
        S_MOVEDIV: begin
          if (div_done) begin
            now_r[cnt_r] <= pos_sat;
          end
        end
        S_YAW: begin
          if (err_w >= YAW_DEADBAND || err_w <= -YAW_DEADBAND) begin
            hdn_r <= hd_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        dt_r  <= q_item.dt;
        tp_r  <= {20'b0, cfg_turn} * {19'b0, q_item.dt};
        sum_r <= '0;
        cnt_r <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= dg[i][32];
          ad_r[i]  <= dg[i][32] ? (~dg[i] + 33'd1) : dg[i];
        end
      end
      S_SQ: begin
        sum_r <= sum_r + sq;
        cnt_r <= cnt_r + 2'd1;
      end
      S_CHK: begin
        rx_r  <= {5'b0, tp_r[38:6]};
        yaw_r <= 1'b1;
      end
      S_SQRT: dist_r <= sh ? {root, 1'b0} : {1'b0, root};
      S_PA:   pa_r   <= {16'b0, dist_r} * {33'b0, cfg_gain};
      S_PB: begin
        pb_r  <= {20'b0, pa_r} * {49'b0, dt_r};
        lim_r <= {28'b0, cfg_move} * {24'b0, POS_DIV};
      end
      S_STEP: begin
        step_r <= cfg_move;
        cnt_r  <= 2'd0;
        rx_r   <= pb_r[51:14];
        yaw_r  <= 1'b0;
      end
      S_RM: begin
        rpl_r <= {25'b0, rx_r[18:0]} * {19'b0, RCP_M};
        rph_r <= {25'b0, rx_r[37:19]} * {19'b0, RCP_M};
      end
      S_RS: rq_r <= rsum[62:38];
      S_RC: begin
        rq_r   <= rq_fix;
        step_r <= rq_fix[MOVE_W-1:0];
        cnt_r  <= 2'd0;
      end
      S_MUL: mp_r <= {24'b0, ad_sel} * {33'b0, step_r};
      S_MOVEDIV: begin
        if (div_done) begin
          if (cnt_r != 2'd2) begin
            cnt_r <= cnt_r + 2'd1;
          end else begin
            rx_r  <= {5'b0, tp_r[38:6]};
            yaw_r <= 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ox_r <= now_r[0];
          oy_r <= now_r[1];
          oz_r <= now_r[2];
          oh_r <= hdn_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_cur_x       = ox_r;
  assign out_cur_y       = oy_r;
  assign out_cur_z       = oz_r;
  assign out_cur_heading = oh_r;

endmodule
`default_nettype wire

// ----- hdl/pose_slew_follower_top.sv -----
// Top level of the pose slew follower: configuration registers, front end and back end.
//
// Input channel (in_*): one item per handshake; kind 0 sets the target pose, kind 1
// also snaps the current pose to it, kind 2 is a time tick of in_elapsed_us.
// Every item yields exactly one result item on the out_* channel with the pose after it.
// A two-entry queue sits between the front end and the back end, so in_ready stays
// high while the back end works, until the queue is full.
// With an idle back end, a set or snap item passes from the queue through S_IDLE and
// S_DONE to the output register. A tick within the snap distance skips the square
// root and the divider and only computes the turn limit; any other tick runs the
// 32-step square root, three passes through a 26-step divider for the axis moves
// and reciprocal multiplications for the turn limit and, unless the step is capped,
// for the step limit. Items are carried out one at a time.
// The configuration channel (cfg_*) is always ready and should only be written while
// the block is idle; indexes beyond the register list are ignored.
// Synchronous reset clears the pose, the target and the queue and loads the register
// defaults. When the receiver stalls, the result stays in the output register and
// the back end holds the next result until the register frees up.
`default_nettype none
module pose_slew_follower_top import psf_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_kind,
  input  wire logic signed [POS_W-1:0]   in_pos_x,
  input  wire logic signed [POS_W-1:0]   in_pos_y,
  input  wire logic signed [POS_W-1:0]   in_pos_z,
  input  wire logic signed [HD_W-1:0]    in_heading,
  input  wire logic [DT_W-1:0]           in_elapsed_us,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [POS_W-1:0]        out_cur_x,
  output logic signed [POS_W-1:0]        out_cur_y,
  output logic signed [POS_W-1:0]        out_cur_z,
  output logic signed [HD_W-1:0]         out_cur_heading,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  logic [GAIN_W-1:0] gain_r;
  logic [MOVE_W-1:0] move_r;
  logic [TURN_W-1:0] turn_r;
  logic              q_valid;
  logic              q_pop;
  item_t             q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      move_r <= MOVE_RST;
      turn_r <= TURN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN: gain_r <= cfg_data[GAIN_W-1:0];
        CFG_MOVE: move_r <= cfg_data[MOVE_W-1:0];
        CFG_TURN: turn_r <= cfg_data[TURN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  psf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_heading    (in_heading),
    .in_elapsed_us (in_elapsed_us),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  psf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .cfg_gain        (gain_r),
    .cfg_move        (move_r),
    .cfg_turn        (turn_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cur_x       (out_cur_x),
    .out_cur_y       (out_cur_y),
    .out_cur_z       (out_cur_z),
    .out_cur_heading (out_cur_heading)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cur_heading <= 16'sd23040 && out_cur_heading > -16'sd23040))
    else $error("result heading outside the wrapped range");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench of the pose slew follower: directed and random items against a predictor.
`default_nettype none
module tb import psf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = KIND_SET;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [HD_W-1:0] in_heading = '0;
  logic [DT_W-1:0] in_elapsed_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] out_cur_x, out_cur_y, out_cur_z;
  logic signed [HD_W-1:0] out_cur_heading;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [HD_W-1:0] hd;
  } pose_t;

  pose_t pose_queue[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  longint unsigned gain_reg, move_reg, turn_reg;
  longint now_p[3], goal_p[3], now_hd, goal_hd;

  pose_slew_follower_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint wrap_heading(longint v);
    longint m;
    m = v % 46080;
    if (m < 0) m += 46080;
    if (m > 23040) m -= 46080;
    return m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic advance_follower(longint unsigned dt);
    longint d[3], mv, err, lim;
    longint unsigned a[3], sum, distance, step, prod;
    int sh;
    sh = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = goal_p[i] - now_p[i];
      a[i] = d[i] < 0 ? -d[i] : d[i];
      if (a[i] >= (64'd1 << 31)) sh = 1;
    end
    for (int i = 0; i < 3; i++) sum += (a[i] >> sh) * (a[i] >> sh);
    if (sh == 0 && sum <= 6) begin
      for (int i = 0; i < 3; i++) now_p[i] = goal_p[i];
    end else begin
      distance = int_sqrt(sum) << sh;
      if (dt == 0 || distance == 0) begin
        step = 0;
      end else begin
        prod = distance * gain_reg;
        if (prod > (move_reg * 64'd256000000) / dt) step = move_reg;
        else step = (prod * dt) / 64'd256000000;
      end
      if (distance != 0) begin
        for (int i = 0; i < 3; i++) begin
          mv = (d[i] * longint'(step)) / longint'(distance);
          mv += now_p[i];
          if (mv > 64'sd2147483647) mv = 64'sd2147483647;
          if (mv < -64'sd2147483648) mv = -64'sd2147483648;
          now_p[i] = mv;
        end
      end
    end
    err = wrap_heading(goal_hd - now_hd);
    lim = longint'((turn_reg * dt) / 64'd1000000);
    if (err >= 13 || err <= -13) begin
      if (err > lim) err = lim;
      if (err < -lim) err = -lim;
      now_hd = wrap_heading(now_hd + err);
    end
  endtask

  task automatic predict_pose(logic [1:0] kind, logic signed [POS_W-1:0] x,
                              logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                              logic signed [HD_W-1:0] hd, logic [DT_W-1:0] dt);
    pose_t p;
    if (kind == KIND_SET || kind == KIND_SNAP) begin
      goal_p[0] = x;
      goal_p[1] = y;
      goal_p[2] = z;
      goal_hd = hd;
      if (kind == KIND_SNAP) begin
        for (int i = 0; i < 3; i++) now_p[i] = goal_p[i];
        now_hd = wrap_heading(goal_hd);
      end
    end else if (kind == KIND_TICK) begin
      advance_follower(dt);
    end
    p.x = now_p[0][31:0];
    p.y = now_p[1][31:0];
    p.z = now_p[2][31:0];
    p.hd = now_hd[15:0];
    pose_queue.push_back(p);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = pose_queue.pop_front();
        if (out_cur_x !== e.x) report_mismatch("cur_x", out_cur_x, e.x);
        if (out_cur_y !== e.y) report_mismatch("cur_y", out_cur_y, e.y);
        if (out_cur_z !== e.z) report_mismatch("cur_z", out_cur_z, e.z);
        if (out_cur_heading !== e.hd) report_mismatch("cur_heading", out_cur_heading, e.hd);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic [1:0] kind, logic signed [POS_W-1:0] x,
                           logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                           logic signed [HD_W-1:0] hd, logic [DT_W-1:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_heading <= hd;
    in_elapsed_us <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pose(kind, x, y, z, hd, dt);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pose_queue.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, longint unsigned v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GAIN) gain_reg = v & 64'hFFFF;
    else if (idx == CFG_MOVE) move_reg = v & 64'hFFFFFF;
    else if (idx == CFG_TURN) turn_reg = v & 64'h7FFFF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return $signed($urandom_range(8)) - 4;
      default: return $signed($urandom_range(200000)) - 100000;
    endcase
  endfunction

  function automatic logic signed [HD_W-1:0] rand_heading();
    if ($urandom_range(9) == 0) return $urandom();
    return $signed($urandom_range(46080)) - 23040;
  endfunction

  function automatic logic [DT_W-1:0] rand_elapsed();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 0;
      default: return $urandom_range(50000);
    endcase
  endfunction

  task automatic send_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(19);
      if (k < 3) send_item(KIND_SET, rand_pos(), rand_pos(), rand_pos(), rand_heading(), $urandom());
      else if (k < 5) send_item(KIND_SNAP, rand_pos(), rand_pos(), rand_pos(), rand_heading(), $urandom());
      else if (k == 5) send_item(2'd3, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      else send_item(KIND_TICK, $urandom(), $urandom(), $urandom(), $urandom(), rand_elapsed());
    end
  endtask

  task automatic test_directed();
    send_item(KIND_TICK, 0, 0, 0, 0, 20'hFFFFF);
    send_item(KIND_SET, 32'sh7FFFFFFF, 32'sh80000000, 5, 16'sd23040, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 16666);
    send_item(KIND_TICK, 0, 0, 0, 0, 20'hFFFFF);
    send_item(KIND_SNAP, 32'sh80000000, 32'sh7FFFFFFF, -1, -16'sd23040, 0);
    send_item(KIND_SET, 1, 1, 2, -16'sd23039, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 0);
    send_item(KIND_SNAP, 0, 0, 0, 16'sh7FFF, 0);
    send_item(KIND_SNAP, 10, 0, 0, 16'sh8000, 0);
    send_item(KIND_SET, 12, 1, 1, 16'sd12, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 100);
    send_item(KIND_SET, 10000, -20000, 300, 16'sd13, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 1000);
    send_item(2'd3, -1, -1, -1, -1, 20'hFFFFF);
    send_item(KIND_TICK, 0, 0, 0, 0, 20'h55555);
    send_item(KIND_TICK, 0, 0, 0, 0, 20'hAAAAA);
  endtask

  task automatic test_register_extremes();
    write_register(CFG_GAIN, 16'hFFFF);
    write_register(CFG_MOVE, 24'hFFFFFF);
    write_register(CFG_TURN, 460800);
    send_random(40);
    write_register(CFG_GAIN, 0);
    write_register(CFG_MOVE, 0);
    write_register(CFG_TURN, 0);
    send_random(30);
    write_register(2'd3, 24'h123456);
    write_register(CFG_GAIN, $urandom_range(65535));
    write_register(CFG_MOVE, $urandom_range(24'hFFFFFF));
    write_register(CFG_TURN, $urandom_range(460800));
    send_random(30);
    write_register(CFG_GAIN, 2560);
    write_register(CFG_MOVE, 25600);
    write_register(CFG_TURN, 92160);
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(200);
    send_idle_pct = 83; recv_stall_pct = 0;  send_random(100);
    send_idle_pct = 0;  recv_stall_pct = 83; send_random(100);
    send_idle_pct = 9;  recv_stall_pct = 9;  send_random(150);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 2000;
    send_random(10);
    wait_drained();
    send_random(10);
  endtask

  initial begin
    gain_reg = 2560;
    move_reg = 25600;
    turn_reg = 92160;
    for (int i = 0; i < 3; i++) begin
      now_p[i] = 0;
      goal_p[i] = 0;
    end
    now_hd = 0;
    goal_hd = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_register_extremes();
    test_idle_phases();
    test_backpressure();
    wait_drained();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/psf_pkg.sv
hdl/psf_front.sv
hdl/psf_sqrt.sv
hdl/psf_div.sv
hdl/psf_back.sv
hdl/pose_slew_follower_top.sv
tb/tb.sv
